FILE: rtl/wht_pkg.sv
// Shared types and constants for the water heater thermostat.
// Holds the mode encoding, button codes, reset values and the state structs.
// No dependencies.
package wht_pkg;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_NORMAL  = 2'd1,
    MODE_SETTING = 2'd2
  } mode_t;

  localparam logic [1:0] BTN_JUST_PRESSED  = 2'd1;
  localparam logic [1:0] BTN_JUST_RELEASED = 2'd3;

  localparam logic [2:0] REG_PRESET_TEMP      = 3'd0;
  localparam logic [2:0] REG_SP_FLOOR         = 3'd1;
  localparam logic [2:0] REG_SP_CEILING       = 3'd2;
  localparam logic [2:0] REG_SP_DELTA         = 3'd3;
  localparam logic [2:0] REG_BAND             = 3'd4;
  localparam logic [2:0] REG_LEAVE_PERIODS    = 3'd5;
  localparam logic [2:0] REG_TICKS_PER_PERIOD = 3'd6;

  localparam logic [7:0]  RST_PRESET_TEMP      = 8'd60;
  localparam logic [7:0]  RST_SP_FLOOR         = 8'd35;
  localparam logic [7:0]  RST_SP_CEILING       = 8'd75;
  localparam logic [7:0]  RST_SP_DELTA         = 8'd5;
  localparam logic [7:0]  RST_BAND             = 8'd5;
  localparam logic [15:0] RST_LEAVE_PERIODS    = 16'd250;
  localparam logic [7:0]  RST_TICKS_PER_PERIOD = 8'd4;

  typedef struct packed {
    logic [7:0]  sp_floor;
    logic [7:0]  sp_ceiling;
    logic [7:0]  sp_delta;
    logic [7:0]  band;
    logic [15:0] leave_periods;
    logic [7:0]  ticks_per_period;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  setpoint;
    logic [7:0]  tick_count;
    logic [15:0] idle_count;
    logic        heater;
    logic        cooler;
  } state_t;

  typedef struct packed {
    logic [7:0] sensed_temp;
    logic [1:0] onoff_button;
    logic [1:0] up_button;
    logic [1:0] down_button;
  } item_t;

endpackage

FILE: rtl/wht_step.sv
// Combinational control step: tick divider, thermostat and setpoint editing.
// Maps the current state and one tick item to the next state.
// Depends on wht_pkg.
module wht_step import wht_pkg::*; (
  input  cfg_t   cfg,
  input  state_t cur,
  input  item_t  item,
  output state_t nxt,
  output logic   step_ran
);

  logic [7:0]  tick_inc;
  logic [7:0]  low_temp;
  logic [8:0]  high_temp;
  logic [8:0]  up_sum;
  logic [7:0]  down_diff;
  logic [15:0] idle_inc;
  logic        onoff_press;
  logic        up_press;
  logic        down_press;

  assign tick_inc    = cur.tick_count + 8'd1;
  assign low_temp    = (cur.setpoint > cfg.band) ? cur.setpoint - cfg.band : 8'd0;
  assign high_temp   = {1'b0, cur.setpoint} + {1'b0, cfg.band};
  assign up_sum      = {1'b0, cur.setpoint} + {1'b0, cfg.sp_delta};
  assign down_diff   = cur.setpoint - cfg.sp_delta;
  assign idle_inc    = cur.idle_count + 16'd1;
  assign onoff_press = (item.onoff_button == BTN_JUST_PRESSED);
  assign up_press    = (item.up_button == BTN_JUST_PRESSED);
  assign down_press  = (item.down_button == BTN_JUST_PRESSED);

  always_comb begin
    nxt            = cur;
    nxt.tick_count = tick_inc;
    step_ran       = 1'b0;
    if (tick_inc >= cfg.ticks_per_period) begin
      nxt.tick_count = 8'd0;
      step_ran       = 1'b1;
      unique case (cur.mode)
        MODE_NORMAL: begin
          // A running drive stops only at an exact setpoint match.
          if (!cur.heater && !cur.cooler) begin
            if (item.sensed_temp <= low_temp) begin
              nxt.heater = 1'b1;
            end else if ({1'b0, item.sensed_temp} >= high_temp) begin
              nxt.cooler = 1'b1;
            end
          end else if (cur.heater && item.sensed_temp == cur.setpoint) begin
            nxt.heater = 1'b0;
          end else if (cur.cooler && item.sensed_temp == cur.setpoint) begin
            nxt.cooler = 1'b0;
          end
          if (onoff_press) begin
            nxt.mode = MODE_OFF;
          end else if (item.down_button == BTN_JUST_RELEASED ||
                       item.up_button == BTN_JUST_RELEASED) begin
            nxt.mode = MODE_SETTING;
          end
        end
        MODE_SETTING: begin
          if (up_press) begin
            nxt.idle_count = 16'd0;
            nxt.setpoint   = (up_sum > {1'b0, cfg.sp_ceiling}) ? cfg.sp_ceiling : up_sum[7:0];
          end else if (down_press) begin
            nxt.idle_count = 16'd0;
            if (cur.setpoint < cfg.sp_delta || down_diff < cfg.sp_floor) begin
              nxt.setpoint = cfg.sp_floor;
            end else begin
              nxt.setpoint = down_diff;
            end
          end else begin
            nxt.idle_count = idle_inc;
            if (idle_inc >= cfg.leave_periods) begin
              nxt.idle_count = 16'd0;
              nxt.mode       = MODE_NORMAL;
            end
          end
          if (onoff_press) begin
            nxt.mode = MODE_OFF;
          end
        end
        default: begin
          nxt.mode   = onoff_press ? MODE_NORMAL : MODE_OFF;
          nxt.heater = 1'b0;
          nxt.cooler = 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/water_heater_thermostat.sv
// Top level of the water heater thermostat: stream ports, configuration
// registers, state registers and the two-register pipeline.
// Depends on wht_pkg and wht_step.
//
// Usage: each transaction on the s_ side is one timer tick carrying the
// averaged temperature and the three button states. Every accepted tick
// produces exactly one transaction on the m_ side with the heater and cooler
// drives, the mode and setpoint after the tick, and a flag telling whether a
// control step ran on it.
// A tick passes through the input register and then the result register, where
// m_tvalid rises; one tick is taken per cycle while the receiver does not stall.
// An input register feeds combinational compare and add logic that
// updates the state and loads the result register in the same edge.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready then drops until m_tready returns, and nothing is lost.
// The configuration channel is always ready; a write to the preset register
// also loads the setpoint. Writes are expected only while no tick is in
// flight. Reset (rst, synchronous) restores the configuration and state
// registers to defaults, clears the pipeline and enters off mode, setpoint 60.
module water_heater_thermostat import wht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] sensed_temp, [9:8] onoff_button, [11:10] up_button,
  // [13:12] down_button, [15:14] zero
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] heater_drive, [1] cooler_drive, [3:2] mode, [11:4] setpoint,
  // [12] step_ran, [15:13] zero
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  item_t  in_item;
  logic   in_valid;
  logic   step_ran;
  logic   advance;
  logic   cfg_write;

  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  wht_step u_step (
    .cfg      (cfg),
    .cur      (state),
    .item     (in_item),
    .nxt      (state_next),
    .step_ran (step_ran)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.sensed_temp  <= s_tdata[7:0];
      in_item.onoff_button <= s_tdata[9:8];
      in_item.up_button    <= s_tdata[11:10];
      in_item.down_button  <= s_tdata[13:12];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'd0, step_ran, state_next.setpoint, state_next.mode,
                  state_next.cooler, state_next.heater};
    end
  end

  // Thermostat state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode       <= MODE_OFF;
      state.setpoint   <= RST_PRESET_TEMP;
      state.tick_count <= 8'd0;
      state.idle_count <= 16'd0;
      state.heater     <= 1'b0;
      state.cooler     <= 1'b0;
    end else if (cfg_write && cfg_index == REG_PRESET_TEMP) begin
      state.setpoint <= cfg_data[7:0];
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Configuration registers; the preset value lives only in the setpoint.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sp_floor         <= RST_SP_FLOOR;
      cfg.sp_ceiling       <= RST_SP_CEILING;
      cfg.sp_delta         <= RST_SP_DELTA;
      cfg.band             <= RST_BAND;
      cfg.leave_periods    <= RST_LEAVE_PERIODS;
      cfg.ticks_per_period <= RST_TICKS_PER_PERIOD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SP_FLOOR:         cfg.sp_floor         <= cfg_data[7:0];
        REG_SP_CEILING:       cfg.sp_ceiling       <= cfg_data[7:0];
        REG_SP_DELTA:         cfg.sp_delta         <= cfg_data[7:0];
        REG_BAND:             cfg.band             <= cfg_data[7:0];
        REG_LEAVE_PERIODS:    cfg.leave_periods    <= cfg_data;
        REG_TICKS_PER_PERIOD: cfg.ticks_per_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
